// ===== rtl/jhtd_pkg.sv =====
// shared types, codes and defaults for the canonical huffman table decoder
package jhtd_pkg;

    // default table limits
    localparam int MAX_CODE_LENGTH_DEF = 16;
    localparam int MAX_SYMBOLS_DEF     = 256;

    // fixed field widths
    localparam int CMD_W    = 2;
    localparam int LEN_W    = 5;
    localparam int SYM_W    = 8;
    localparam int WIN_W    = 16;
    localparam int STATUS_W = 2;
    localparam int CODE_W   = 17;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // command codes on the input tuser
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DECODE = 2'd2;

    // classified operations handed to the back end
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_DECODE = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOMATCH = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REJECT  = 2'd2;

    // one classified item in the queue
    typedef struct packed {
        logic [1:0]       op;
        logic             len_ok;
        logic [LEN_W-1:0] len;
        logic [SYM_W-1:0] sym;
        logic [WIN_W-1:0] window;
    } item_t;

endpackage

// ===== rtl/jhtd_front.sv =====
// input side: accepts items, classifies the command and queues them for the back end
module jhtd_front
    import jhtd_pkg::*;
#(
    parameter int MAX_CODE_LENGTH = MAX_CODE_LENGTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // code_length[4:0], symbol_value[12:5], code_window[28:13]
    input  logic [1:0]  s_axis_tuser,   // command[1:0]
    output logic        q_valid,
    input  logic        q_ready,
    output item_t       q_item
);

    localparam int QPW = $clog2(QUEUE_DEPTH);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    item_t            cls_item;
    logic [LEN_W-1:0] in_len;
    logic             push;
    logic             pop;

    item_t            q_mem_reg [QUEUE_DEPTH];
    logic [QPW-1:0]   wr_ptr_reg;
    logic [QPW-1:0]   rd_ptr_reg;
    logic [QCW-1:0]   cnt_reg;

    assign in_len = s_axis_tdata[4:0];

    // classify the command and check the length range
    always_comb
    begin
        cls_item.len    = in_len;
        cls_item.sym    = s_axis_tdata[12:5];
        cls_item.window = s_axis_tdata[28:13];
        cls_item.len_ok = (in_len != '0) && (in_len <= LEN_W'(MAX_CODE_LENGTH));
        case (s_axis_tuser)
            CMD_CLEAR:  cls_item.op = OP_CLEAR;
            CMD_INSERT: cls_item.op = OP_INSERT;
            CMD_DECODE: cls_item.op = OP_DECODE;
            default:    cls_item.op = OP_NOP;
        endcase
    end

    // queue handshakes
    assign s_axis_tready = (cnt_reg != QCW'(QUEUE_DEPTH));
    assign push          = s_axis_tvalid && s_axis_tready;
    assign q_valid       = (cnt_reg != '0);
    assign pop           = q_valid && q_ready;
    assign q_item        = q_mem_reg[rd_ptr_reg];

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= cls_item;
        end
    end

    // queue pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= QPW'(wr_ptr_reg + 1'b1);
            end
            if (pop)
            begin
                rd_ptr_reg <= QPW'(rd_ptr_reg + 1'b1);
            end
            if (push && !pop)
            begin
                cnt_reg <= QCW'(cnt_reg + 1'b1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= QCW'(cnt_reg - 1'b1);
            end
        end
    end

endmodule

// ===== rtl/jhtd_back.sv =====
// execution side: holds the table, runs clear, insert and decode, drives the result item
module jhtd_back
    import jhtd_pkg::*;
#(
    parameter int MAX_CODE_LENGTH = MAX_CODE_LENGTH_DEF,
    parameter int MAX_SYMBOLS     = MAX_SYMBOLS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    output logic        q_ready,
    input  item_t       q_item,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // decoded_symbol[7:0], decoded_length[12:8]
    output logic [1:0]  m_axis_tuser    // status[1:0]
);

    localparam int AW  = $clog2(MAX_SYMBOLS);
    localparam int CW  = $clog2(MAX_SYMBOLS + 1);
    localparam int LIW = $clog2(MAX_CODE_LENGTH);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_MATCH = 2'd1;
    localparam logic [1:0] S_READ  = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    // sequencer
    logic [1:0] state_reg;
    logic [1:0] state_next;

    // table state
    logic [WIN_W-1:0]  first_code_reg [MAX_CODE_LENGTH];
    logic [CW-1:0]     first_idx_reg  [MAX_CODE_LENGTH];
    logic [CW-1:0]     count_reg      [MAX_CODE_LENGTH];
    logic [CODE_W-1:0] next_code_reg;
    logic [LEN_W-1:0]  last_len_reg;
    logic [CW-1:0]     loaded_reg;
    logic [SYM_W-1:0]  store_mem [MAX_SYMBOLS];

    // decode pipeline
    logic              lane_hit_reg [MAX_CODE_LENGTH];
    logic [CW-1:0]     lane_idx_reg [MAX_CODE_LENGTH];
    logic              match_hit_reg;
    logic [LEN_W-1:0]  match_len_reg;
    logic [SYM_W-1:0]  rd_data_reg;

    // pending result and output register
    logic [STATUS_W-1:0] res_status_reg;
    logic [SYM_W-1:0]    res_sym_reg;
    logic [LEN_W-1:0]    res_len_reg;
    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [SYM_W-1:0]    out_sym_reg;
    logic [LEN_W-1:0]    out_len_reg;

    logic             take;
    logic             out_free;
    logic [LEN_W-1:0] shift_amt;
    logic [31:0]      shifted;
    logic             overflow;
    logic             store_full;
    logic             ins_reject;
    logic [LIW-1:0]   ins_lane;

    logic [WIN_W-1:0] lane_prefix [MAX_CODE_LENGTH];
    logic [WIN_W:0]   lane_diff   [MAX_CODE_LENGTH];
    logic             lane_hit    [MAX_CODE_LENGTH];
    logic [CW-1:0]    lane_idx    [MAX_CODE_LENGTH];

    logic             sel_hit;
    logic [LEN_W-1:0] sel_len;
    logic [CW-1:0]    sel_idx;

    assign q_ready  = (state_reg == S_IDLE);
    assign take     = q_valid && q_ready;
    assign out_free = !out_valid_reg || m_axis_tready;

    // insert checks: canonical code at the new length and its fit
    assign shift_amt  = q_item.len - last_len_reg;
    assign shifted    = 32'(next_code_reg) << shift_amt;
    assign overflow   = (shifted >> q_item.len) != 32'd0;
    assign store_full = (loaded_reg >= CW'(MAX_SYMBOLS));
    assign ins_reject = !q_item.len_ok || (q_item.len < last_len_reg) || store_full || overflow;
    assign ins_lane   = LIW'(q_item.len - 5'd1);

    // per-length compare lanes
    always_comb
    begin
        for (int l = 0; l < MAX_CODE_LENGTH; l++)
        begin
            lane_prefix[l] = q_item.window >> (15 - l);
            lane_diff[l]   = {1'b0, lane_prefix[l]} - {1'b0, first_code_reg[l]};
            lane_hit[l]    = (count_reg[l] != '0) && !lane_diff[l][WIN_W]
                             && (lane_diff[l][WIN_W-1:0] < WIN_W'(count_reg[l]));
            lane_idx[l]    = first_idx_reg[l] + lane_diff[l][CW-1:0];
        end
    end

    // shortest matching length wins
    always_comb
    begin
        sel_hit = 1'b0;
        sel_len = '0;
        sel_idx = '0;
        for (int l = MAX_CODE_LENGTH - 1; l >= 0; l--)
        begin
            if (lane_hit_reg[l])
            begin
                sel_hit = 1'b1;
                sel_len = LEN_W'(l + 1);
                sel_idx = lane_idx_reg[l];
            end
        end
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    state_next = (q_item.op == OP_DECODE) ? S_MATCH : S_DONE;
                end
            end
            S_MATCH: state_next = S_READ;
            S_READ:  state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // symbol store: write on insert, registered read on decode
    always_ff @(posedge clk)
    begin
        if (take && (q_item.op == OP_INSERT) && !ins_reject)
        begin
            store_mem[loaded_reg[AW-1:0]] <= q_item.sym;
        end
        if (state_reg == S_MATCH)
        begin
            rd_data_reg <= store_mem[sel_idx[AW-1:0]];
        end
    end

    // decode pipeline and pending result
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            for (int l = 0; l < MAX_CODE_LENGTH; l++)
            begin
                lane_hit_reg[l] <= lane_hit[l];
                lane_idx_reg[l] <= lane_idx[l];
            end
            res_sym_reg <= '0;
            res_len_reg <= '0;
            case (q_item.op)
                OP_INSERT: res_status_reg <= ins_reject ? ST_REJECT : ST_OK;
                default:   res_status_reg <= ST_OK;
            endcase
        end
        if (state_reg == S_MATCH)
        begin
            match_hit_reg <= sel_hit;
            match_len_reg <= sel_len;
        end
        if (state_reg == S_READ)
        begin
            res_status_reg <= match_hit_reg ? ST_OK : ST_NOMATCH;
            res_sym_reg    <= match_hit_reg ? rd_data_reg : '0;
            res_len_reg    <= match_hit_reg ? match_len_reg : '0;
        end
        if ((state_reg == S_DONE) && out_free)
        begin
            out_status_reg <= res_status_reg;
            out_sym_reg    <= res_sym_reg;
            out_len_reg    <= res_len_reg;
        end
    end

    // control state and table registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            next_code_reg <= '0;
            last_len_reg  <= LEN_W'(1);
            loaded_reg    <= '0;
            for (int l = 0; l < MAX_CODE_LENGTH; l++)
            begin
                first_code_reg[l] <= '0;
                first_idx_reg[l]  <= '0;
                count_reg[l]      <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            // output register
            if ((state_reg == S_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            // table updates
            if (take)
            begin
                case (q_item.op)
                    OP_CLEAR:
                    begin
                        next_code_reg <= '0;
                        last_len_reg  <= LEN_W'(1);
                        loaded_reg    <= '0;
                        for (int l = 0; l < MAX_CODE_LENGTH; l++)
                        begin
                            first_code_reg[l] <= '0;
                            first_idx_reg[l]  <= '0;
                            count_reg[l]      <= '0;
                        end
                    end
                    OP_INSERT:
                    begin
                        if (!ins_reject)
                        begin
                            if (count_reg[ins_lane] == '0)
                            begin
                                first_code_reg[ins_lane] <= shifted[WIN_W-1:0];
                                first_idx_reg[ins_lane]  <= loaded_reg;
                            end
                            count_reg[ins_lane] <= CW'(count_reg[ins_lane] + 1'b1);
                            loaded_reg          <= CW'(loaded_reg + 1'b1);
                            next_code_reg       <= shifted[CODE_W-1:0] + 1'b1;
                            last_len_reg        <= q_item.len;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_len_reg, out_sym_reg};
    assign m_axis_tuser  = out_status_reg;

    // symbol count never passes the store size
    assert property (@(posedge clk) disable iff (!rst_n)
        loaded_reg <= CW'(MAX_SYMBOLS))
        else $error("symbol count beyond store size");

    // last accepted length stays a legal code length
    assert property (@(posedge clk) disable iff (!rst_n)
        (last_len_reg != '0) && (last_len_reg <= LEN_W'(MAX_CODE_LENGTH)))
        else $error("last inserted length out of range");

    // decode walks select then store read
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MATCH) |=> (state_reg == S_READ))
        else $error("decode sequence broken");

    // a finished result reaches the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DONE) && out_free) |=> (out_valid_reg && (state_reg == S_IDLE)))
        else $error("result not handed to output");

    // an ok result never reports a length beyond the longest code
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg == ST_OK)) |-> (out_len_reg <= LEN_W'(MAX_CODE_LENGTH)))
        else $error("matched length out of range");

endmodule

// ===== rtl/jpeg_huffman_table_decoder_top.sv =====
// top level of the canonical huffman table decoder
// Each input item is a command in tuser (clear, insert symbol with its code length, or decode a
// 16-bit window, first stream bit in the msb) and yields exactly one result item with a status,
// the decoded symbol and the number of bits it used. Inserts must come in non-decreasing length
// order and get canonical codes. The front end takes an item whenever its two-entry queue has
// room, so input keeps flowing while a result waits at the output. The back end works on one
// item at a time and takes the next only once the result has gone to the output register; a
// decode passes through lane compare over all lengths, priority select with the registered
// symbol store read, result, and output load, in that order.
module jpeg_huffman_table_decoder_top
    import jhtd_pkg::*;
#(
    parameter int MAX_CODE_LENGTH = MAX_CODE_LENGTH_DEF,
    parameter int MAX_SYMBOLS     = MAX_SYMBOLS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // code_length[4:0], symbol_value[12:5], code_window[28:13]
    input  logic [1:0]  s_axis_tuser,   // command[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // decoded_symbol[7:0], decoded_length[12:8]
    output logic [1:0]  m_axis_tuser    // status[1:0]
);

    logic  q_valid;
    logic  q_ready;
    item_t q_item;

    // accept and classify
    jhtd_front #(
        .MAX_CODE_LENGTH (MAX_CODE_LENGTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_item        (q_item)
    );

    // table and execution
    jhtd_back #(
        .MAX_CODE_LENGTH (MAX_CODE_LENGTH),
        .MAX_SYMBOLS     (MAX_SYMBOLS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_item        (q_item),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ===== bench/jpeg_huffman_table_decoder_top_test.sv =====
// self-checking bench for the canonical huffman table decoder, with its own table model
module jpeg_huffman_table_decoder_top_test;
    import jhtd_pkg::*;

    // the unused command value, which leaves the table unchanged
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    // cycles waited after the last pending result before a test ends
    localparam int SETTLE_CYCLES = 20;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SYM_W-1:0]    sym;
        logic [LEN_W-1:0]    len;
    } result_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // code_length[4:0], symbol_value[12:5], code_window[28:13]
    logic [1:0]  s_axis_tuser;   // command[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;   // decoded_symbol[7:0], decoded_length[12:8]
    logic [1:0]  m_axis_tuser;   // status[1:0]

    // table model state
    logic [15:0] first_code   [16];
    logic [8:0]  first_index  [16];
    logic [8:0]  code_count   [16];
    logic [7:0]  symbol_mem   [256];
    logic [16:0] next_code;
    logic [4:0]  last_len;
    logic [8:0]  symbols_held;

    result_t pending_results[$];
    int      mismatch_count = 0;
    int      send_idle_pct  = 0;
    int      stall_pct      = 0;
    int      hold_left      = 0;
    bit      hold_start     = 0;

    jpeg_huffman_table_decoder_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit
    initial
    begin
        #400000;
        $display("end of test: mismatches");
        $finish;
    end

    // empty the model table
    function automatic void table_clear();
        for (int i = 0; i < 16; i++)
        begin
            first_code[i]  = '0;
            first_index[i] = '0;
            code_count[i]  = '0;
        end
        next_code    = '0;
        last_len     = 5'd1;
        symbols_held = '0;
    endfunction

    // canonical insert, returns the status
    function automatic logic [STATUS_W-1:0] table_insert(logic [4:0] len, logic [7:0] sym);
        int unsigned code;
        if (len < 1 || len > MAX_CODE_LENGTH_DEF)
            return ST_REJECT;
        if (len < last_len)
            return ST_REJECT;
        if (symbols_held >= MAX_SYMBOLS_DEF)
            return ST_REJECT;
        code = 32'(next_code) << (len - last_len);
        if (code >= (32'd1 << len))
            return ST_REJECT;
        if (code_count[len-1] == 0)
        begin
            first_code[len-1]  = code[15:0];
            first_index[len-1] = symbols_held;
        end
        code_count[len-1]        = code_count[len-1] + 9'd1;
        symbol_mem[symbols_held[7:0]] = sym;
        symbols_held             = symbols_held + 9'd1;
        next_code                = 17'(code + 1);
        last_len                 = len;
        return ST_OK;
    endfunction

    // expected result of one accepted item
    function automatic result_t huffman_predict(logic [1:0] cmd, logic [4:0] len,
                                                logic [7:0] sym, logic [15:0] win);
        result_t     res;
        int unsigned prefix;
        int unsigned offs;
        res = '{status: ST_OK, sym: '0, len: '0};
        if (cmd == CMD_CLEAR)
            table_clear();
        else if (cmd == CMD_INSERT)
            res.status = table_insert(len, sym);
        else if (cmd == CMD_DECODE)
        begin
            res.status = ST_NOMATCH;
            for (int l = 1; l <= MAX_CODE_LENGTH_DEF; l++)
            begin
                prefix = 32'(win) >> (16 - l);
                offs   = prefix - 32'(first_code[l-1]);
                if (code_count[l-1] != 0 && prefix >= first_code[l-1] && offs < code_count[l-1])
                begin
                    res.status = ST_OK;
                    res.sym    = symbol_mem[8'(first_index[l-1] + offs)];
                    res.len    = 5'(l);
                    break;
                end
            end
        end
        return res;
    endfunction

    // predict on every accepted input item
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            pending_results.push_back(huffman_predict(s_axis_tuser, s_axis_tdata[4:0],
                                                      s_axis_tdata[12:5], s_axis_tdata[28:13]));
    end

    // compare every accepted result with the oldest prediction
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result status %0d symbol %0h length %0d", $time,
                         m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[12:8]);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tuser !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status,
                             m_axis_tuser);
                    mismatch_count++;
                end
                if (m_axis_tdata[7:0] !== want.sym)
                begin
                    $display("%0t: symbol expected %0h actual %0h", $time, want.sym,
                             m_axis_tdata[7:0]);
                    mismatch_count++;
                end
                if (m_axis_tdata[12:8] !== want.len)
                begin
                    $display("%0t: length expected %0d actual %0d", $time, want.len,
                             m_axis_tdata[12:8]);
                    mismatch_count++;
                end
            end
        end
    end

    // result side ready, with random stalls and the long hold-off
    always @(negedge clk)
    begin
        if (hold_start)
        begin
            hold_left  = 300;
            hold_start = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // offer one item and wait until it is taken
    task automatic send_item(logic [1:0] cmd, logic [4:0] len, logic [7:0] sym,
                             logic [15:0] win);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, win, sym, len};
        s_axis_tuser  <= cmd;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // let every pending result come out
    task automatic wait_drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // empty table decode and the unused command
    task automatic test_empty_table();
        send_item(CMD_DECODE, 5'd0, 8'h00, 16'h0000);
        send_item(CMD_DECODE, 5'd0, 8'h00, 16'hffff);
        send_item(CMD_UNUSED, 5'd31, 8'hff, 16'hffff);
        send_item(CMD_UNUSED, 5'd0, 8'h00, 16'h0000);
        wait_drain();
    endtask

    // canonical codes, decreasing length, out of range lengths, full code space
    task automatic test_canonical_build();
        send_item(CMD_CLEAR, 5'd0, 8'h00, 16'h0000);
        send_item(CMD_INSERT, 5'd1, 8'h00, 16'h0000);
        send_item(CMD_INSERT, 5'd3, 8'hff, 16'h0000);
        send_item(CMD_INSERT, 5'd3, 8'h3c, 16'h0000);
        send_item(CMD_INSERT, 5'd2, 8'h11, 16'h0000);
        send_item(CMD_INSERT, 5'd0, 8'h22, 16'h0000);
        send_item(CMD_INSERT, 5'd17, 8'h33, 16'h0000);
        send_item(CMD_INSERT, 5'd31, 8'h44, 16'h0000);
        send_item(CMD_INSERT, 5'd16, 8'hc3, 16'h0000);
        send_item(CMD_DECODE, 5'd0, 8'h00, 16'h0000);
        send_item(CMD_DECODE, 5'd0, 8'h00, 16'h8000);
        send_item(CMD_DECODE, 5'd0, 8'h00, 16'ha000);
        send_item(CMD_DECODE, 5'd0, 8'h00, 16'hc000);
        send_item(CMD_DECODE, 5'd0, 8'h00, 16'hc001);
        send_item(CMD_DECODE, 5'd0, 8'h00, 16'hffff);
        // length one fills up after two codes
        send_item(CMD_CLEAR, 5'd0, 8'h00, 16'h0000);
        send_item(CMD_INSERT, 5'd1, 8'h5a, 16'h0000);
        send_item(CMD_INSERT, 5'd1, 8'ha5, 16'h0000);
        send_item(CMD_INSERT, 5'd1, 8'h77, 16'h0000);
        send_item(CMD_INSERT, 5'd2, 8'h88, 16'h0000);
        send_item(CMD_DECODE, 5'd0, 8'h00, 16'h7fff);
        send_item(CMD_DECODE, 5'd0, 8'h00, 16'hffff);
        // cleared table finds nothing
        send_item(CMD_CLEAR, 5'd0, 8'h00, 16'h0000);
        send_item(CMD_DECODE, 5'd0, 8'h00, 16'h0000);
        wait_drain();
    endtask

    // all symbol slots used, then one more
    task automatic test_store_full();
        send_item(CMD_CLEAR, 5'd0, 8'h00, 16'h0000);
        for (int i = 0; i < MAX_SYMBOLS_DEF; i++)
            send_item(CMD_INSERT, 5'd9, 8'($urandom), 16'($urandom));
        send_item(CMD_INSERT, 5'd9, 8'h12, 16'h0000);
        send_item(CMD_INSERT, 5'd10, 8'h34, 16'h0000);
        send_item(CMD_DECODE, 5'd0, 8'h00, 16'h0000);
        send_item(CMD_DECODE, 5'd0, 8'h00, 16'h7f80);
        send_item(CMD_DECODE, 5'd0, 8'h00, 16'h8000);
        wait_drain();
    endtask

    // random tables in sorted length order, decodes, and some noise
    task automatic test_random_tables(int n_items);
        int sent;
        int n_sym;
        int n_dec;
        int len;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(9) < 8)
            begin
                send_item(CMD_CLEAR, 5'($urandom), 8'($urandom), 16'($urandom));
                n_sym = $urandom_range(1, 40);
                len   = $urandom_range(1, 8);
                for (int i = 0; i < n_sym; i++)
                begin
                    if ($urandom_range(15) == 0)
                        len = $urandom_range(len, 16);
                    else if ($urandom_range(2) == 0 && len < 16)
                        len++;
                    send_item(CMD_INSERT, 5'(len), 8'($urandom), 16'($urandom));
                end
                n_dec = $urandom_range(4, 24);
                for (int i = 0; i < n_dec; i++)
                    send_item(CMD_DECODE, 5'($urandom), 8'($urandom), 16'($urandom));
                sent += 1 + n_sym + n_dec;
            end
            else
            begin
                send_item(2'($urandom), 5'($urandom), 8'($urandom), 16'($urandom));
                sent++;
            end
        end
        wait_drain();
    endtask

    // long output hold-off while decodes keep coming
    task automatic test_backpressure();
        send_item(CMD_CLEAR, 5'd0, 8'h00, 16'h0000);
        for (int i = 0; i < 6; i++)
            send_item(CMD_INSERT, 5'd3, 8'($urandom), 16'h0000);
        @(posedge clk);
        hold_start = 1;
        for (int i = 0; i < 24; i++)
            send_item(CMD_DECODE, 5'd0, 8'h00, 16'($urandom));
        wait_drain();
    endtask

    // reset and test sequence
    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_CLEAR;
        table_clear();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_table();
        test_canonical_build();
        test_store_full();

        send_idle_pct = 0;
        stall_pct     = 0;
        test_random_tables(115);
        send_idle_pct = 49;
        stall_pct     = 0;
        test_random_tables(115);
        send_idle_pct = 0;
        stall_pct     = 49;
        test_random_tables(115);
        send_idle_pct = 34;
        stall_pct     = 34;
        test_random_tables(115);

        send_idle_pct = 0;
        stall_pct     = 0;
        test_backpressure();

        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
